@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ hw/rtl/jomt_pkg.sv @@
// shared types, codes and helpers of the json member tokenizer
package jomt_pkg;

  localparam int PEND_DEPTH_DEF = 16;
  localparam int MAX_NEST_DEF   = 255;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  typedef enum logic [2:0] {
    KIND_KEY_BYTE   = 3'd0,
    KIND_KEY_END    = 3'd1,
    KIND_VAL_BYTE   = 3'd2,
    KIND_MEMBER_END = 3'd3,
    KIND_OBJ_END    = 3'd4,
    KIND_NO_OBJ     = 3'd5,
    KIND_ERROR      = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_FLUSH,
    ST_POST
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic flush_emit;
    logic post_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic plan_pre;
    logic plan_post;
    logic pre_last;
    logic post_any;
    logic post_last;
    logic out_free;
  } dp_status_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

@@ hw/rtl/jomt_ram.sv @@
// generic single-port-write ram with registered read
module jomt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/jomt_ctrl.sv @@
// sequencing state machine of the json member tokenizer
module jomt_ctrl import jomt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.plan_pre) state_next = ST_READ;
        else if (status.plan_post) state_next = ST_POST;
        else state_next = ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          if (!status.pre_last) state_next = ST_READ;
          else if (status.post_any) state_next = ST_POST;
          else state_next = ST_IDLE;
        end
      end
      ST_POST: begin
        if (status.out_free && status.post_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_READ: begin
      end
      ST_FLUSH: begin
        cmd.flush_emit = status.out_free;
      end
      ST_POST: begin
        cmd.post_emit = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/jomt_dp.sv @@
// datapath: parse state, held whitespace buffer, result queue, output register
module jomt_dp import jomt_pkg::*; #(
  parameter int PEND_DEPTH = PEND_DEPTH_DEF,
  parameter int MAX_NEST   = MAX_NEST_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [2:0] m_kind,
  output logic [7:0] m_data,
  output logic       m_last
);

  localparam int AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int CW = $clog2(PEND_DEPTH + 1);
  localparam int NW = $clog2(MAX_NEST + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(PEND_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(PEND_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [NW-1:0] NEST_MAX = NW'(MAX_NEST);

  typedef enum logic [2:0] {
    PH_START,
    PH_SEEK_KEY,
    PH_KEY,
    PH_AFTER_KEY,
    PH_VALUE_LEAD,
    PH_VALUE,
    PH_DONE
  } phase_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  logic [7:0]    cur_byte;
  logic          cur_last;
  phase_t        phase;
  logic [NW-1:0] nest;
  logic          in_str;
  logic          prev_bs;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] held_cnt;
  logic [CW-1:0] rem;
  result_t       queue [3];
  logic [1:0]    queue_cnt;
  logic          clr_pend;
  logic          wr_pend;

  phase_t        plan_phase;
  logic [NW-1:0] plan_nest;
  logic          plan_in_str;
  logic          plan_bs;
  logic [CW-1:0] plan_pre_cnt;
  logic          plan_clr;
  logic          plan_wr_now;
  logic          plan_wr_late;
  result_t       plan_queue [3];
  logic [1:0]    plan_qcnt;

  logic          ram_we;
  logic [7:0]    ram_rdata;

  // per-byte decision: state update, held bytes to release, queued results
  always_comb begin
    logic    ws;
    logic    val_go;
    result_t cand [4];
    logic    cand_v [4];
    ws           = is_ws(cur_byte);
    val_go       = 1'b0;
    plan_phase   = phase;
    plan_nest    = nest;
    plan_in_str  = in_str;
    plan_bs      = prev_bs;
    plan_pre_cnt = '0;
    plan_clr     = 1'b0;
    plan_wr_now  = 1'b0;
    plan_wr_late = 1'b0;
    for (int i = 0; i < 4; i++) begin
      cand[i]   = '{kind: KIND_ERROR, data: 8'h00};
      cand_v[i] = 1'b0;
    end
    unique case (phase) inside
      PH_START: begin
        if (cur_byte == CH_LBRACE) begin
          plan_phase = PH_SEEK_KEY;
        end else if (!ws) begin
          cand[0]    = '{kind: KIND_NO_OBJ, data: 8'h00};
          cand_v[0]  = 1'b1;
          plan_phase = PH_DONE;
        end
      end
      PH_SEEK_KEY: begin
        if (cur_byte == CH_RBRACE) begin
          cand[0]    = '{kind: KIND_OBJ_END, data: 8'h00};
          cand_v[0]  = 1'b1;
          plan_phase = PH_DONE;
        end else if (cur_byte == CH_QUOTE) begin
          plan_phase = PH_KEY;
        end else if (!ws) begin
          cand[0]    = '{kind: KIND_ERROR, data: 8'h00};
          cand_v[0]  = 1'b1;
          plan_phase = PH_DONE;
        end
      end
      PH_KEY: begin
        cand_v[0] = 1'b1;
        if (cur_byte == CH_QUOTE) begin
          cand[0]    = '{kind: KIND_KEY_END, data: 8'h00};
          plan_phase = PH_AFTER_KEY;
        end else begin
          cand[0] = '{kind: KIND_KEY_BYTE, data: cur_byte};
        end
      end
      PH_AFTER_KEY: begin
        if (cur_byte == CH_COLON) begin
          plan_phase  = PH_VALUE_LEAD;
          plan_nest   = '0;
          plan_in_str = 1'b0;
          plan_bs     = 1'b0;
          plan_clr    = 1'b1;
        end else if (!ws) begin
          cand[0]    = '{kind: KIND_ERROR, data: 8'h00};
          cand_v[0]  = 1'b1;
          plan_phase = PH_DONE;
        end
      end
      PH_VALUE_LEAD, PH_VALUE: begin
        val_go = (phase == PH_VALUE) || !ws;
        if (val_go) begin
          if (ws) begin
            plan_bs = 1'b0;
            if (held_cnt == CNT_FULL) begin
              plan_pre_cnt = CNT_ONE;
              plan_wr_late = 1'b1;
            end else begin
              plan_wr_now = 1'b1;
            end
          end else if (!in_str && (nest == '0) &&
                       ((cur_byte == CH_COMMA) || (cur_byte == CH_RBRACE))) begin
            plan_clr  = 1'b1;
            cand[0]   = '{kind: KIND_MEMBER_END, data: 8'h00};
            cand_v[0] = 1'b1;
            if (cur_byte == CH_RBRACE) begin
              cand[1]    = '{kind: KIND_OBJ_END, data: 8'h00};
              cand_v[1]  = 1'b1;
              plan_phase = PH_DONE;
            end else begin
              plan_phase = PH_SEEK_KEY;
            end
          end else begin
            plan_pre_cnt = held_cnt;
            cand[0]      = '{kind: KIND_VAL_BYTE, data: cur_byte};
            cand_v[0]    = 1'b1;
            if (in_str) begin
              if ((cur_byte == CH_QUOTE) && !prev_bs) plan_in_str = 1'b0;
            end else if (cur_byte == CH_QUOTE) begin
              plan_in_str = 1'b1;
            end else if ((cur_byte == CH_LBRACE) || (cur_byte == CH_LBRACKET)) begin
              if (nest < NEST_MAX) plan_nest = nest + NW'(1);
            end else if ((cur_byte == CH_RBRACE) || (cur_byte == CH_RBRACKET)) begin
              if (nest != '0) plan_nest = nest - NW'(1);
            end
            plan_bs    = (cur_byte == CH_BSLASH);
            plan_phase = PH_VALUE;
          end
        end
      end
      default: begin
        plan_phase = PH_DONE;
      end
    endcase

    if (cur_last) begin
      case (plan_phase) inside
        PH_START: begin
          cand[2]   = '{kind: KIND_NO_OBJ, data: 8'h00};
          cand_v[2] = 1'b1;
        end
        PH_SEEK_KEY: begin
          cand[2]   = '{kind: KIND_OBJ_END, data: 8'h00};
          cand_v[2] = 1'b1;
        end
        PH_KEY, PH_AFTER_KEY: begin
          cand[2]   = '{kind: KIND_ERROR, data: 8'h00};
          cand_v[2] = 1'b1;
        end
        PH_VALUE_LEAD, PH_VALUE: begin
          cand[2]   = '{kind: KIND_MEMBER_END, data: 8'h00};
          cand_v[2] = 1'b1;
          cand[3]   = '{kind: KIND_OBJ_END, data: 8'h00};
          cand_v[3] = 1'b1;
        end
        default: begin
        end
      endcase
      plan_phase   = PH_START;
      plan_nest    = '0;
      plan_in_str  = 1'b0;
      plan_bs      = 1'b0;
      plan_clr     = 1'b1;
      plan_wr_now  = 1'b0;
      plan_wr_late = 1'b0;
    end

    // pack the candidate results in order
    plan_qcnt = 2'd0;
    for (int i = 0; i < 3; i++) begin
      plan_queue[i] = '{kind: KIND_ERROR, data: 8'h00};
    end
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (plan_qcnt != 2'd3)) begin
        plan_queue[plan_qcnt] = cand[i];
        plan_qcnt             = plan_qcnt + 2'd1;
      end
    end
  end

  assign status.plan_pre  = (plan_pre_cnt != '0);
  assign status.plan_post = (plan_qcnt != 2'd0);
  assign status.pre_last  = (rem == CNT_ONE);
  assign status.post_any  = (queue_cnt != 2'd0);
  assign status.post_last = (queue_cnt == 2'd1);
  assign status.out_free  = !m_tvalid || m_tready;

  assign ram_we = (cmd.eval && (plan_pre_cnt == '0) && !plan_clr && plan_wr_now) ||
                  (cmd.flush_emit && (rem == CNT_ONE) && !clr_pend && wr_pend);

  jomt_ram #(
    .WIDTH(8),
    .DEPTH(PEND_DEPTH)
  ) u_held (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(cur_byte),
    .raddr(head),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      nest      <= '0;
      in_str    <= 1'b0;
      prev_bs   <= 1'b0;
      head      <= '0;
      tail      <= '0;
      held_cnt  <= '0;
      rem       <= '0;
      queue_cnt <= 2'd0;
      clr_pend  <= 1'b0;
      wr_pend   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.eval) begin
        phase     <= plan_phase;
        nest      <= plan_nest;
        in_str    <= plan_in_str;
        prev_bs   <= plan_bs;
        rem       <= plan_pre_cnt;
        queue_cnt <= plan_qcnt;
        if (plan_pre_cnt == '0) begin
          clr_pend <= 1'b0;
          wr_pend  <= 1'b0;
          if (plan_clr) begin
            held_cnt <= '0;
            head     <= tail;
          end else if (plan_wr_now) begin
            tail     <= ptr_inc(tail);
            held_cnt <= held_cnt + CNT_ONE;
          end
        end else begin
          clr_pend <= plan_clr;
          wr_pend  <= plan_wr_late && !plan_clr;
        end
      end
      if (cmd.flush_emit) begin
        rem <= rem - CNT_ONE;
        if ((rem == CNT_ONE) && clr_pend) begin
          held_cnt <= '0;
          head     <= tail;
        end else if ((rem == CNT_ONE) && wr_pend) begin
          head <= ptr_inc(head);
          tail <= ptr_inc(tail);
        end else begin
          head     <= ptr_inc(head);
          held_cnt <= held_cnt - CNT_ONE;
        end
      end
      if (cmd.post_emit) begin
        queue_cnt <= queue_cnt - 2'd1;
      end
      if (cmd.flush_emit || cmd.post_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= in_byte;
      cur_last <= end_of_text;
    end
    if (cmd.eval) begin
      for (int i = 0; i < 3; i++) begin
        queue[i] <= plan_queue[i];
      end
    end else if (cmd.post_emit) begin
      queue[0] <= queue[1];
      queue[1] <= queue[2];
    end
    if (cmd.flush_emit) begin
      m_kind <= KIND_VAL_BYTE;
      m_data <= ram_rdata;
      m_last <= (rem == CNT_ONE) && (queue_cnt == 2'd0);
    end else if (cmd.post_emit) begin
      m_kind <= queue[0].kind;
      m_data <= queue[0].data;
      m_last <= (queue_cnt == 2'd1);
    end
  end

endmodule

@@ hw/rtl/json_object_member_tokenizer_top.sv @@
// top level of the json object member tokenizer
// a byte is taken in idle and decoded in the next cycle in eval; the next byte waits for idle
// queued results (key, value or closing words) leave from the post state while output is free
// each held whitespace byte released is read from the buffer ram in read, then sent in flush
// a byte's first result is registered after eval, or after its held whitespace goes out first
// reset is synchronous; the whitespace buffer ram is not cleared and needs no clearing pass
module json_object_member_tokenizer_top import jomt_pkg::*; #(
  parameter int PEND_DEPTH = PEND_DEPTH_DEF,
  parameter int MAX_NEST   = MAX_NEST_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // data_byte
  output logic [2:0] m_tuser,   // kind
  output logic       m_tlast
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  jomt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  jomt_dp #(
    .PEND_DEPTH(PEND_DEPTH),
    .MAX_NEST  (MAX_NEST)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (s_tdata),
    .end_of_text(s_tlast),
    .cmd        (cmd),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_kind     (m_tuser),
    .m_data     (m_tdata),
    .m_last     (m_tlast)
  );

endmodule

@@ hw/rtl/jomt_checker.sv @@
// port-level checks of the json member tokenizer, bound to the top level
`include "assert_macros.svh"

module jomt_checker import jomt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
  `ASSERT_IMPLY(a_data_zero, clk, rst, m_tvalid && (m_tuser != KIND_KEY_BYTE) && (m_tuser != KIND_VAL_BYTE), m_tdata == 8'h00)
  `ASSERT_IMPLY(a_close_last, clk, rst, m_tvalid && ((m_tuser == KIND_OBJ_END) || (m_tuser == KIND_NO_OBJ) || (m_tuser == KIND_ERROR)), m_tlast)
  `ASSERT_NEXT(a_one_word_busy, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind json_object_member_tokenizer_top jomt_checker u_chk (.*);

@@ test/tb_json_object_member_tokenizer_top.sv @@
// testbench of the json object member tokenizer: scripted and random texts, every word checked
`timescale 1ns / 1ps

module tb_json_object_member_tokenizer_top;
  import jomt_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int NEST_RUN    = 24;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum int {
    PH_START,
    PH_SEEK_KEY,
    PH_KEY,
    PH_AFTER_KEY,
    PH_VALUE_LEAD,
    PH_VALUE,
    PH_DONE
  } parse_phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } token_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;  // in_byte
  logic       s_tlast = 1'b0;   // end_of_text
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // data_byte
  logic [2:0] m_tuser;          // kind
  logic       m_tlast;          // last_of_run

  parse_phase_t tok_phase;
  int unsigned  depth_lvl;
  bit           in_str;
  bit           after_bs;
  logic [7:0]   held_ws[$];
  token_t       step_words[$];
  token_t       token_q[$];
  token_t       head_tok;
  logic [7:0]   text_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  int fail_count = 0;
  int words_checked = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int stall_cycles = 0;

  json_object_member_tokenizer_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit ws_char(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic clear_tokenizer();
    tok_phase = PH_START;
    depth_lvl = 0;
    in_str = 1'b0;
    after_bs = 1'b0;
    held_ws.delete();
  endtask

  task automatic push_word(input kind_t k, input logic [7:0] d);
    token_t t;
    t.kind = k;
    t.data = d;
    t.last = 1'b0;
    step_words.insert(step_words.size(), t);
  endtask

  task automatic member_value(input logic [7:0] c);
    if (ws_char(c)) begin
      after_bs = 1'b0;
      if (held_ws.size() >= PEND_DEPTH_DEF) begin
        push_word(KIND_VAL_BYTE, held_ws.pop_front());
      end
      held_ws.insert(held_ws.size(), c);
    end else if (!in_str && depth_lvl == 0 && (c == CH_COMMA || c == CH_RBRACE)) begin
      held_ws.delete();
      push_word(KIND_MEMBER_END, 8'h00);
      if (c == CH_RBRACE) begin
        push_word(KIND_OBJ_END, 8'h00);
        tok_phase = PH_DONE;
      end else begin
        tok_phase = PH_SEEK_KEY;
      end
    end else begin
      foreach (held_ws[i]) push_word(KIND_VAL_BYTE, held_ws[i]);
      held_ws.delete();
      push_word(KIND_VAL_BYTE, c);
      if (in_str) begin
        if (c == CH_QUOTE && !after_bs) in_str = 1'b0;
      end else if (c == CH_QUOTE) begin
        in_str = 1'b1;
      end else if (c == CH_LBRACE || c == CH_LBRACKET) begin
        if (depth_lvl < MAX_NEST_DEF) depth_lvl++;
      end else if (c == CH_RBRACE || c == CH_RBRACKET) begin
        if (depth_lvl > 0) depth_lvl--;
      end
      after_bs = (c == CH_BSLASH);
      tok_phase = PH_VALUE;
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input bit eot);
    token_t t;
    step_words.delete();
    case (tok_phase)
      PH_START: begin
        if (c == CH_LBRACE) begin
          tok_phase = PH_SEEK_KEY;
        end else if (!ws_char(c)) begin
          push_word(KIND_NO_OBJ, 8'h00);
          tok_phase = PH_DONE;
        end
      end
      PH_SEEK_KEY: begin
        if (c == CH_RBRACE) begin
          push_word(KIND_OBJ_END, 8'h00);
          tok_phase = PH_DONE;
        end else if (c == CH_QUOTE) begin
          tok_phase = PH_KEY;
        end else if (!ws_char(c)) begin
          push_word(KIND_ERROR, 8'h00);
          tok_phase = PH_DONE;
        end
      end
      PH_KEY: begin
        if (c == CH_QUOTE) begin
          push_word(KIND_KEY_END, 8'h00);
          tok_phase = PH_AFTER_KEY;
        end else begin
          push_word(KIND_KEY_BYTE, c);
        end
      end
      PH_AFTER_KEY: begin
        if (c == CH_COLON) begin
          tok_phase = PH_VALUE_LEAD;
          depth_lvl = 0;
          in_str = 1'b0;
          after_bs = 1'b0;
          held_ws.delete();
        end else if (!ws_char(c)) begin
          push_word(KIND_ERROR, 8'h00);
          tok_phase = PH_DONE;
        end
      end
      PH_VALUE_LEAD: begin
        if (!ws_char(c)) member_value(c);
      end
      PH_VALUE: member_value(c);
      default: ;
    endcase
    if (eot) begin
      case (tok_phase)
        PH_START: push_word(KIND_NO_OBJ, 8'h00);
        PH_SEEK_KEY: push_word(KIND_OBJ_END, 8'h00);
        PH_KEY, PH_AFTER_KEY: push_word(KIND_ERROR, 8'h00);
        PH_VALUE_LEAD, PH_VALUE: begin
          push_word(KIND_MEMBER_END, 8'h00);
          push_word(KIND_OBJ_END, 8'h00);
        end
        default: ;
      endcase
      clear_tokenizer();
    end
    if (step_words.size() != 0) begin
      t = step_words.pop_back();
      t.last = 1'b1;
      step_words.insert(step_words.size(), t);
    end
    foreach (step_words[i]) token_q.insert(token_q.size(), step_words[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit eot);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokenize_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    texts_sent++;
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    foreach (s[i]) add_byte(s[i]);
    send_text();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_ws(input int n);
    repeat (n) add_byte(pick_ws());
  endtask

  task automatic add_key();
    int n;
    logic [7:0] k;
    add_byte(CH_QUOTE);
    n = $urandom_range(4);
    repeat (n) begin
      if ($urandom_range(3) == 0) k = 8'($urandom_range(255));
      else k = 8'($urandom_range(8'h20, 8'h7E));
      if (k == CH_QUOTE) k = CH_BSLASH;
      add_byte(k);
    end
    add_byte(CH_QUOTE);
  endtask

  task automatic add_value(input int lvl);
    int n;
    logic [7:0] ch;
    case ($urandom_range(6))
      0: ;
      1: begin
        if ($urandom_range(1) != 0) add_byte(CH_MINUS);
        n = $urandom_range(1, 4);
        repeat (n) add_byte(8'($urandom_range(8'h30, 8'h39)));
      end
      2: begin
        add_byte(CH_QUOTE);
        n = $urandom_range(5);
        repeat (n) begin
          if ($urandom_range(3) == 0) begin
            add_byte(CH_BSLASH);
            case ($urandom_range(2))
              0: add_byte(CH_QUOTE);
              1: add_byte(CH_BSLASH);
              default: add_byte(CH_SPACE);
            endcase
          end else begin
            ch = 8'($urandom_range(8'h20, 8'h7E));
            if (ch == CH_QUOTE || ch == CH_BSLASH) ch = CH_RBRACE;
            add_byte(ch);
          end
        end
        add_byte(CH_QUOTE);
      end
      3: begin
        if (lvl < 2) begin
          add_byte(CH_LBRACE);
          n = $urandom_range(2);
          for (int i = 0; i < n; i++) begin
            add_key();
            add_byte(CH_COLON);
            add_ws($urandom_range(1));
            add_value(lvl + 1);
            if (i < n - 1) add_byte(CH_COMMA);
          end
          add_byte(CH_RBRACE);
        end else begin
          add_byte(8'($urandom_range(8'h30, 8'h39)));
        end
      end
      4: begin
        add_byte(CH_LBRACKET);
        n = (lvl < 2) ? $urandom_range(3) : 0;
        for (int i = 0; i < n; i++) begin
          add_value(lvl + 1);
          add_ws($urandom_range(1));
          if (i < n - 1) add_byte(CH_COMMA);
        end
        add_byte(CH_RBRACKET);
      end
      5: begin
        add_byte(8'($urandom_range(8'h30, 8'h39)));
        add_ws($urandom_range(1, 20));
        add_byte(8'($urandom_range(8'h30, 8'h39)));
      end
      default: begin
        add_byte(8'h74);
        add_byte(8'h72);
        add_byte(8'h75);
        add_byte(8'h65);
      end
    endcase
  endtask

  task automatic build_object();
    int m;
    text_q.delete();
    add_ws($urandom_range(2));
    add_byte(CH_LBRACE);
    m = $urandom_range(3);
    for (int i = 0; i < m; i++) begin
      add_ws($urandom_range(1));
      add_key();
      add_ws($urandom_range(1));
      add_byte(CH_COLON);
      add_ws($urandom_range(2));
      add_value(0);
      if ($urandom_range(8) == 0) add_ws($urandom_range(15, 20));
      else add_ws($urandom_range(2));
      if (i < m - 1 || $urandom_range(3) == 0) add_byte(CH_COMMA);
    end
    add_ws($urandom_range(1));
    add_byte(CH_RBRACE);
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_outside_object();
    text_q.delete();
    add_byte(8'h00);
    send_text();
    text_q.delete();
    add_byte(CH_SPACE);
    add_byte(CH_LBRACE);
    add_byte(CH_QUOTE);
    add_byte(8'hFF);
    add_byte(CH_QUOTE);
    add_byte(8'h78);
    send_text();
    drain();
  endtask

  task automatic test_member_start();
    send_string("{,}");
    send_string("{\"");
    send_string("{");
    drain();
  endtask

  task automatic test_values();
    send_string("{\"\\\":\"\\\"}\"[}],}");
    send_string("{\"\":}");
    drain();
  endtask

  task automatic test_deep_nesting();
    text_q.delete();
    add_byte(CH_LBRACE);
    add_byte(CH_QUOTE);
    add_byte(8'h64);
    add_byte(CH_QUOTE);
    add_byte(CH_COLON);
    for (int i = 0; i < NEST_RUN; i++) add_byte(i[0] ? CH_LBRACE : CH_LBRACKET);
    add_byte(8'h78);
    repeat (NEST_RUN + 2) add_byte(CH_RBRACKET);
    add_byte(CH_RBRACE);
    send_text();
    drain();
  endtask

  task automatic test_random_texts(input int s_idle, input int r_idle, input int n_items);
    int start_count;
    int pos;
    send_idle = s_idle;
    recv_idle = r_idle;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_items) begin
      if ($urandom_range(9) == 0) begin
        text_q.delete();
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(255)));
      end else begin
        build_object();
        case ($urandom_range(9))
          0: begin
            pos = $urandom_range(text_q.size() - 1);
            text_q[pos] = 8'($urandom_range(255));
          end
          1: begin
            pos = $urandom_range(1, text_q.size());
            while (text_q.size() > pos) void'(text_q.pop_back());
          end
          default: ;
        endcase
      end
      send_text();
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (token_q.size() == 0) begin
        $error("word with nothing expected: kind %0d data %02h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        head_tok = token_q.pop_front();
        words_checked++;
        if (m_tuser !== head_tok.kind) begin
          $error("kind: expected %0d actual %0d", head_tok.kind, m_tuser);
          fail_count++;
        end
        if (m_tdata !== head_tok.data) begin
          $error("data_byte: expected %02h actual %02h", head_tok.data, m_tdata);
          fail_count++;
        end
        if (m_tlast !== head_tok.last) begin
          $error("last_of_run: expected %0d actual %0d", head_tok.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("json_object_member_tokenizer_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    clear_tokenizer();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle = 30;
    recv_idle = 66;
    test_outside_object();
    test_member_start();
    test_values();
    test_random_texts(30, 66, 85);
    test_random_texts(66, 30, 85);
    test_deep_nesting();
    test_random_texts(0, 0, 85);
    repeat (64) @(posedge clk);
    $display("%0d texts, %0d bytes in, %0d words checked", texts_sent, bytes_sent, words_checked);
    $display("covered closings, key/value errors, escapes, trim overflow, nesting and unnesting");
    if (fail_count == 0 && token_q.size() == 0) begin
      $display("json_object_member_tokenizer_top: match");
    end else begin
      $display("json_object_member_tokenizer_top: mismatch");
    end
    $finish;
  end

endmodule
